FILE: design/alp_pkg.sv
// ---------------------------------------------------------------------------
// alp_pkg: shared definitions for the address lease pool
// Message, destination and reply codes, entry status codes, register indexes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package alp_pkg;

   // Default sizes handed to the top level.
   localparam int POOL_DEPTH_DEF  = 1024;
   localparam int CLIENT_BITS_DEF = 16;

   // Configuration register indexes.
   localparam logic [1:0] CSR_POOL_SIZE     = 2'd0;
   localparam logic [1:0] CSR_DEFAULT_LEASE = 2'd1;
   localparam logic [1:0] CSR_MAX_LEASE     = 2'd2;
   localparam logic [1:0] CSR_MIN_LEASE     = 2'd3;

   // Register reset values.
   localparam logic [10:0] POOL_SIZE_RST     = 11'd1024;
   localparam logic [30:0] DEFAULT_LEASE_RST = 31'd3600;
   localparam logic [30:0] MAX_LEASE_RST     = 31'd86400;
   localparam logic [30:0] MIN_LEASE_RST     = 31'd60;

   // Destination codes.
   localparam logic [1:0] DEST_THIS  = 2'd0;
   localparam logic [1:0] DEST_BCAST = 2'd1;

   // Message kinds.
   localparam logic [1:0] KIND_DISCOVER = 2'd0;
   localparam logic [1:0] KIND_REQUEST  = 2'd1;

   // Reply kinds.
   localparam logic [1:0] REPLY_OFFER = 2'd0;
   localparam logic [1:0] REPLY_ACK   = 2'd1;
   localparam logic [1:0] REPLY_NAK   = 2'd2;

   // Entry status codes.
   localparam logic [1:0] ST_FREE = 2'd0;
   localparam logic [1:0] ST_PEND = 2'd1;
   localparam logic [1:0] ST_BUSY = 2'd2;
   localparam logic [1:0] ST_EXP  = 2'd3;

   // Classification of one entry after its expiry check.
   typedef struct packed {
      logic owned;
      logic is_free;
      logic is_expired;
      logic dirty;
   } alp_eval_type;

endpackage

`default_nettype wire

FILE: design/alp_entry_eval.sv
// ---------------------------------------------------------------------------
// alp_entry_eval: expiry check and classification of one pool entry
// Applies the expiry rule to an entry read from the pool, optionally frees
// a pending entry of the client, and reports how the entry classifies.
// ---------------------------------------------------------------------------
`default_nettype none

module alp_entry_eval #(
   parameter int CLIENT_BITS = 16
) (
   input  wire logic [1:0]             status,
   input  wire logic [31:0]            expiry,
   input  wire logic [CLIENT_BITS-1:0] owner,
   input  wire logic [30:0]            now,
   input  wire logic [CLIENT_BITS-1:0] who,
   input  wire logic                   drop_pending,
   output logic [1:0]                  post_status,
   output logic [31:0]                 post_expiry,
   output logic [CLIENT_BITS-1:0]      post_owner,
   output alp_pkg::alp_eval_type       flags
);
   import alp_pkg::*;

   logic hit;
   logic owned;
   logic drop;

   // An entry expires when its nonzero expiry is at or before the time.
   assign hit = (expiry != 32'd0) && (expiry <= {1'b0, now});

   always_comb begin
      post_status = status;
      post_expiry = expiry;
      post_owner  = owner;
      if (hit) begin
         post_expiry = 32'd0;
         if (status == ST_PEND) begin
            post_status = ST_FREE;
            post_owner  = '0;
         end else begin
            post_status = ST_EXP;
         end
      end

      owned = (post_owner != '0) && (post_owner == who);
      drop  = drop_pending && owned && (post_status == ST_PEND);

      // A request to another server releases the client's pending entries.
      if (drop) begin
         post_status = ST_FREE;
         post_expiry = 32'd0;
         post_owner  = '0;
      end

      flags.owned      = owned && !drop;
      flags.is_free    = (post_status == ST_FREE);
      flags.is_expired = (post_status == ST_EXP);
      flags.dirty      = hit || drop;
   end

endmodule

`default_nettype wire

FILE: design/address_lease_pool.sv
// ---------------------------------------------------------------------------
// address_lease_pool: pool of leasable addresses answering lease messages
// Keeps status, expiry and owner per address and answers discover and
// request messages with offers, acknowledges or negative acknowledges.
// ---------------------------------------------------------------------------
// Each accepted message walks the single-port entry memory once over the n
// live entries (n is pool_size clamped to POOL_DEPTH), reading and then
// evaluating and writing back each entry, followed, for a grant, by the lease
// arithmetic and the final entry update. Messages that are filtered out are
// dropped in the idle state. After reset the block clears every entry of the
// memory and holds req_stall high meanwhile; configuration writes are taken
// throughout.
`default_nettype none

module address_lease_pool #(
   parameter int POOL_DEPTH  = alp_pkg::POOL_DEPTH_DEF,
   parameter int CLIENT_BITS = alp_pkg::CLIENT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [30:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [30:0] req_time_now,
   input  wire logic [15:0] req_client_id,
   input  wire logic [1:0]  req_server_kind,
   input  wire logic [1:0]  req_kind,
   input  wire logic [15:0] req_address,
   input  wire logic [30:0] req_expiry_req,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_reply_kind,
   output logic [15:0]      rsp_reply_client,
   output logic [15:0]      rsp_reply_address,
   output logic [31:0]      rsp_reply_expiry
);
   import alp_pkg::*;

   localparam int IDX_W   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
   localparam int ENTRY_W = 2 + 32 + CLIENT_BITS;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_READ  = 4'd2;
   localparam logic [3:0] S_EVAL  = 4'd3;
   localparam logic [3:0] S_LEN   = 4'd4;
   localparam logic [3:0] S_MIN   = 4'd5;
   localparam logic [3:0] S_MAX   = 4'd6;
   localparam logic [3:0] S_SUM   = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   // Configuration registers.
   logic [10:0] pool_size_ff;
   logic [30:0] default_lease_ff;
   logic [30:0] max_lease_ff;
   logic [30:0] min_lease_ff;

   // Sequencer and message state.
   logic [3:0]             state_ff, state_in;
   logic [CNT_W-1:0]       idx_ff, idx_in, idx_nx;
   logic [CNT_W-1:0]       n_ff, n_in, live_n;
   logic [30:0]            now_ff, now_in;
   logic [CLIENT_BITS-1:0] who_ff, who_in;
   logic [15:0]            addr_ff, addr_in;
   logic [30:0]            rexp_ff, rexp_in;
   logic                   disc_ff, disc_in;
   logic                   drop_ff, drop_in;
   logic                   own_ok_ff, own_ok_in;
   logic                   free_ok_ff, free_ok_in;
   logic                   exp_ok_ff, exp_ok_in;
   logic [IDX_W-1:0]       own_idx_ff, own_idx_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]       exp_idx_ff, exp_idx_in;
   logic                   hit_ff, hit_in;
   logic                   nak_ff, nak_in;
   logic [IDX_W-1:0]       tgt_ff, tgt_in;
   logic signed [32:0]     diff_ff, diff_in;
   logic signed [32:0]     len_ff, len_in;
   logic [31:0]            exp_ff, exp_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rkind_ff, rkind_in;
   logic [15:0] rclient_ff, rclient_in;
   logic [15:0] raddr_ff, raddr_in;
   logic [31:0] rexpiry_ff, rexpiry_in;

   // Entry memory.
   logic [ENTRY_W-1:0] mem [POOL_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [IDX_W-1:0]   mem_raddr;
   logic [ENTRY_W-1:0] mem_wdata;

   logic                   accept;
   logic                   pass;
   logic [1:0]             post_status;
   logic [31:0]            post_expiry;
   logic [CLIENT_BITS-1:0] post_owner;
   alp_eval_type           ev;
   logic                   at_addr;

   assign req_stall         = (state_ff != S_IDLE);
   assign accept            = req_valid && !req_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reply_kind    = rkind_ff;
   assign rsp_reply_client  = rclient_ff;
   assign rsp_reply_address = raddr_ff;
   assign rsp_reply_expiry  = rexpiry_ff;

   // Only broadcast discovers and directed requests are processed.
   assign pass = ((req_server_kind == DEST_BCAST) && (req_kind == KIND_DISCOVER)) ||
                 ((req_server_kind != DEST_BCAST) && (req_kind == KIND_REQUEST));

   assign live_n = ({6'd0, pool_size_ff} >= 17'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH)
                                                             : CNT_W'(pool_size_ff);
   assign idx_nx  = idx_ff + 1'b1;
   assign at_addr = ((17'(idx_ff) + 17'd1) == {1'b0, addr_ff});

   alp_entry_eval #(
      .CLIENT_BITS (CLIENT_BITS)
   ) u_eval (
      .status       (rd_ff[ENTRY_W-1 -: 2]),
      .expiry       (rd_ff[CLIENT_BITS +: 32]),
      .owner        (rd_ff[CLIENT_BITS-1:0]),
      .now          (now_ff),
      .who          (who_ff),
      .drop_pending (drop_ff),
      .post_status  (post_status),
      .post_expiry  (post_expiry),
      .post_owner   (post_owner),
      .flags        (ev)
   );

   // Sequencer: clearing sweep, pool walk, lease arithmetic and reply.
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      n_in        = n_ff;
      now_in      = now_ff;
      who_in      = who_ff;
      addr_in     = addr_ff;
      rexp_in     = rexp_ff;
      disc_in     = disc_ff;
      drop_in     = drop_ff;
      own_ok_in   = own_ok_ff;
      free_ok_in  = free_ok_ff;
      exp_ok_in   = exp_ok_ff;
      own_idx_in  = own_idx_ff;
      free_idx_in = free_idx_ff;
      exp_idx_in  = exp_idx_ff;
      hit_in      = hit_ff;
      nak_in      = nak_ff;
      tgt_in      = tgt_ff;
      diff_in     = diff_ff;
      len_in      = len_ff;
      exp_in      = exp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rkind_in    = rkind_ff;
      rclient_in  = rclient_ff;
      raddr_in    = raddr_ff;
      rexpiry_in  = rexpiry_ff;
      mem_we      = 1'b0;
      mem_waddr   = idx_ff[IDX_W-1:0];
      mem_raddr   = idx_ff[IDX_W-1:0];
      mem_wdata   = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            idx_in = idx_nx;
            if (idx_nx == CNT_W'(POOL_DEPTH)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               now_in     = req_time_now;
               who_in     = CLIENT_BITS'(req_client_id);
               addr_in    = req_address;
               rexp_in    = req_expiry_req;
               disc_in    = (req_kind == KIND_DISCOVER);
               drop_in    = (req_kind == KIND_REQUEST) &&
                            (req_server_kind != DEST_THIS);
               own_ok_in  = 1'b0;
               free_ok_in = 1'b0;
               exp_ok_in  = 1'b0;
               hit_in     = 1'b0;
               n_in       = live_n;
               idx_in     = '0;
               if (pass) begin
                  state_in = (live_n == '0) ? S_LEN : S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (ev.dirty) begin
               mem_we    = 1'b1;
               mem_wdata = {post_status, post_expiry, post_owner};
            end
            if (ev.owned && !own_ok_ff) begin
               own_ok_in  = 1'b1;
               own_idx_in = idx_ff[IDX_W-1:0];
            end
            if (ev.is_free && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = idx_ff[IDX_W-1:0];
            end
            if (ev.is_expired && !exp_ok_ff) begin
               exp_ok_in  = 1'b1;
               exp_idx_in = idx_ff[IDX_W-1:0];
            end
            if (at_addr) begin
               hit_in = ev.owned;
            end
            idx_in   = idx_nx;
            state_in = (idx_nx == n_ff) ? S_LEN : S_READ;
         end
         S_LEN: begin
            diff_in  = $signed({2'b00, rexp_ff}) - $signed({2'b00, now_ff});
            nak_in   = 1'b0;
            state_in = S_MIN;
            if (disc_ff) begin
               if (own_ok_ff) begin
                  tgt_in = own_idx_ff;
               end else if (free_ok_ff) begin
                  tgt_in = free_idx_ff;
               end else if (exp_ok_ff) begin
                  tgt_in = exp_idx_ff;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (drop_ff) begin
               state_in = S_IDLE;
            end else begin
               tgt_in = IDX_W'(addr_ff - 16'd1);
               if (!hit_ff) begin
                  nak_in   = 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_MIN: begin
            if (rexp_ff == 31'd0) begin
               len_in = $signed({2'b00, default_lease_ff});
            end else if (diff_ff < $signed({2'b00, min_lease_ff})) begin
               len_in = $signed({2'b00, min_lease_ff});
            end else begin
               len_in = diff_ff;
            end
            state_in = S_MAX;
         end
         S_MAX: begin
            if ((rexp_ff != 31'd0) && (len_ff > $signed({2'b00, max_lease_ff}))) begin
               len_in = $signed({2'b00, max_lease_ff});
            end
            state_in = S_SUM;
         end
         S_SUM: begin
            exp_in   = {1'b0, now_ff} + len_ff[31:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            // Wait for the result register to be free, then commit.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rclient_in   = 16'(who_ff);
               if (nak_ff) begin
                  rkind_in   = REPLY_NAK;
                  raddr_in   = addr_ff;
                  rexpiry_in = 32'd0;
               end else begin
                  rkind_in   = disc_ff ? REPLY_OFFER : REPLY_ACK;
                  raddr_in   = disc_ff ? 16'(17'(tgt_ff) + 17'd1) : addr_ff;
                  rexpiry_in = exp_ff;
                  mem_we     = 1'b1;
                  mem_waddr  = tgt_ff;
                  mem_wdata  = {(disc_ff ? ST_PEND : ST_BUSY), exp_ff, who_ff};
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers take a write in any state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff     <= POOL_SIZE_RST;
         default_lease_ff <= DEFAULT_LEASE_RST;
         max_lease_ff     <= MAX_LEASE_RST;
         min_lease_ff     <= MIN_LEASE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POOL_SIZE:     pool_size_ff     <= csr_wdata[10:0];
            CSR_DEFAULT_LEASE: default_lease_ff <= csr_wdata;
            CSR_MAX_LEASE:     max_lease_ff     <= csr_wdata;
            CSR_MIN_LEASE:     min_lease_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      now_ff      <= now_in;
      who_ff      <= who_in;
      addr_ff     <= addr_in;
      rexp_ff     <= rexp_in;
      disc_ff     <= disc_in;
      drop_ff     <= drop_in;
      own_ok_ff   <= own_ok_in;
      free_ok_ff  <= free_ok_in;
      exp_ok_ff   <= exp_ok_in;
      own_idx_ff  <= own_idx_in;
      free_idx_ff <= free_idx_in;
      exp_idx_ff  <= exp_idx_in;
      hit_ff      <= hit_in;
      nak_ff      <= nak_in;
      tgt_ff      <= tgt_in;
      diff_ff     <= diff_in;
      len_ff      <= len_in;
      exp_ff      <= exp_in;
      rkind_ff    <= rkind_in;
      rclient_ff  <= rclient_in;
      raddr_ff    <= raddr_in;
      rexpiry_ff  <= rexpiry_in;
   end

   // No message is taken while the memory is being cleared.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall)
      else $error("message taken during clearing sweep");

   // A refusal always carries a zero expiry.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_reply_kind == REPLY_NAK)) |-> (rsp_reply_expiry == 32'd0))
      else $error("refusal with nonzero expiry");

   // Offers and acknowledges name a real pool address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_reply_kind != REPLY_NAK)) |-> (rsp_reply_address != 16'd0))
      else $error("grant of address zero");

   // A new result is only loaded once the previous one has been transferred.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rexpiry_ff))
      else $error("pending result overwritten");

endmodule

`default_nettype wire
